// ===== src/wmts_pkg.sv =====
package wmts_pkg;

    // Default depth of the queue between the front and back ends.
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0] SLEEP_TICKS_RESET = 16'd1220;

    localparam logic [4:0]  HOUR_MAX    = 5'd23;
    localparam logic [5:0]  MINUTE_MAX  = 6'd59;
    localparam logic [5:0]  SECOND_MAX  = 6'd59;
    localparam logic [3:0]  MONTH_MAX   = 4'd12;
    localparam logic [10:0] YEAR_MIN    = 11'd2020;
    localparam logic [10:0] YEAR_MAX    = 11'd2030;
    localparam logic [2:0]  WEEKDAY_MAX = 3'd7;
    localparam logic [4:0]  DATE_LONG   = 5'd31;
    localparam logic [4:0]  DATE_SHORT  = 5'd30;
    localparam logic [4:0]  DATE_OTHER  = 5'd29;

    localparam logic [4:0]  HOUR_RESET    = 5'd0;
    localparam logic [5:0]  MINUTE_RESET  = 6'd0;
    localparam logic [5:0]  SECOND_RESET  = 6'd0;
    localparam logic [4:0]  DATE_RESET    = 5'd1;
    localparam logic [3:0]  MONTH_RESET   = 4'd1;
    localparam logic [10:0] YEAR_RESET    = 11'd2020;
    localparam logic [2:0]  WEEKDAY_RESET = 3'd1;

    typedef enum logic [1:0] {
        KIND_POLL = 2'd0,
        KIND_TICK = 2'd1,
        KIND_LOAD = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PAGE_CLOCK    = 2'd0,
        PAGE_BINARY   = 2'd1,
        PAGE_SETTINGS = 2'd2
    } page_t;

    typedef enum logic [2:0] {
        FIELD_HOUR    = 3'd0,
        FIELD_MINUTE  = 3'd1,
        FIELD_SECOND  = 3'd2,
        FIELD_DATE    = 3'd3,
        FIELD_MONTH   = 3'd4,
        FIELD_YEAR    = 3'd5,
        FIELD_WEEKDAY = 3'd6
    } field_t;

    typedef enum logic [1:0] {
        BTN_NONE  = 2'd0,
        BTN_RIGHT = 2'd1,
        BTN_LEFT  = 2'd2,
        BTN_BOTH  = 2'd3
    } button_t;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [4:0]  date;
        logic [3:0]  month;
        logic [10:0] year;
        logic [2:0]  weekday;
    } clock_time_t;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        kind_t       kind;
        button_t     buttons;
        clock_time_t load_time;
    } cmd_t;

    // One result as held in the output register.
    typedef struct packed {
        page_t       page;
        field_t      field;
        clock_time_t held;
        logic        sleep_request;
        logic        clock_write;
    } result_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic valid;
        logic pop;
    } queue_hs_t;

    function automatic logic [4:0] month_length(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DATE_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DATE_SHORT;
            default:                                    len = DATE_OTHER;
        endcase
        return len;
    endfunction

endpackage

// ===== src/wmts_front.sv =====
module wmts_front import wmts_pkg::*; (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // kind
    // right_press, left_press, hours, minutes, seconds, day_of_month,
    // month, year, weekday, zero fill
    input  logic [47:0] s_tdata,
    input  logic        queue_full,
    output logic        push,
    output cmd_t        cmd
);

    logic right_press;
    logic left_press;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    assign right_press = s_tdata[0];
    assign left_press  = s_tdata[1];

    // Buttons only matter on a poll; other kinds travel with no press.
    always_comb begin
        cmd.kind = kind_t'(s_tuser);
        if (cmd.kind == KIND_POLL) begin
            cmd.buttons = button_t'({left_press, right_press});
        end else begin
            cmd.buttons = BTN_NONE;
        end
        cmd.load_time.hours   = s_tdata[6:2];
        cmd.load_time.minutes = s_tdata[12:7];
        cmd.load_time.seconds = s_tdata[18:13];
        cmd.load_time.date    = s_tdata[23:19];
        cmd.load_time.month   = s_tdata[27:24];
        cmd.load_time.year    = s_tdata[38:28];
        cmd.load_time.weekday = s_tdata[41:39];
    end

endmodule

// ===== src/wmts_queue.sv =====
module wmts_queue import wmts_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output queue_hs_t hs_out,
    input  logic pop,
    output cmd_t pop_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full         = (count_reg == FULL_CNT);
    assign hs_out.valid = (count_reg != '0);
    assign hs_out.pop   = pop;
    assign pop_cmd      = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/wmts_back.sv =====
module wmts_back import wmts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    input  logic        queue_valid,
    input  cmd_t        cmd,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output result_t     result
);

    logic [15:0]  sleep_ticks_reg;
    page_t        page_reg, page_next;
    field_t       field_reg, field_next;
    logic         inc_pending_reg, inc_pending_next;
    logic [15:0]  idle_count_reg, idle_count_next;
    logic         sleep_pending_reg, sleep_pending_next;
    clock_time_t  held_reg, held_next, bumped;
    logic         out_valid_reg, out_valid_next;
    result_t      result_reg, result_next;
    logic         sleep_out, write_out;

    logic [5:0]   hour_inc;
    logic [6:0]   minute_inc;
    logic [6:0]   second_inc;
    logic [5:0]   date_inc;
    logic [4:0]   month_inc;
    logic [11:0]  year_inc;
    logic [3:0]   weekday_inc;
    logic [15:0]  idle_inc;

    assign pop      = queue_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

    // Held time with the selected field advanced and wrapped.
    always_comb begin
        hour_inc    = {1'b0, held_reg.hours} + 6'd1;
        minute_inc  = {1'b0, held_reg.minutes} + 7'd1;
        second_inc  = {1'b0, held_reg.seconds} + 7'd1;
        date_inc    = {1'b0, held_reg.date} + 6'd1;
        month_inc   = {1'b0, held_reg.month} + 5'd1;
        year_inc    = {1'b0, held_reg.year} + 12'd1;
        weekday_inc = {1'b0, held_reg.weekday} + 4'd1;
        bumped      = held_reg;
        case (field_reg)
            FIELD_HOUR: begin
                bumped.hours = (hour_inc > {1'b0, HOUR_MAX}) ? '0 : hour_inc[4:0];
            end
            FIELD_MINUTE: begin
                bumped.minutes = (minute_inc > {1'b0, MINUTE_MAX}) ? '0 : minute_inc[5:0];
            end
            FIELD_SECOND: begin
                bumped.seconds = (second_inc > {1'b0, SECOND_MAX}) ? '0 : second_inc[5:0];
            end
            FIELD_DATE: begin
                bumped.date = (date_inc > {1'b0, month_length(held_reg.month)}) ?
                              5'd1 : date_inc[4:0];
            end
            FIELD_MONTH: begin
                bumped.month = (month_inc > {1'b0, MONTH_MAX}) ? 4'd1 : month_inc[3:0];
            end
            FIELD_YEAR: begin
                bumped.year = (year_inc > {1'b0, YEAR_MAX}) ? YEAR_MIN : year_inc[10:0];
            end
            FIELD_WEEKDAY: begin
                bumped.weekday = (weekday_inc > {1'b0, WEEKDAY_MAX}) ?
                                 3'd1 : weekday_inc[2:0];
            end
            default: begin
                bumped = held_reg;
            end
        endcase
    end

    always_comb begin
        page_next          = page_reg;
        field_next         = field_reg;
        inc_pending_next   = inc_pending_reg;
        idle_count_next    = idle_count_reg;
        sleep_pending_next = sleep_pending_reg;
        held_next          = held_reg;
        sleep_out          = 1'b0;
        write_out          = 1'b0;
        idle_inc           = idle_count_reg + 16'd1;

        if (pop) begin
            unique case (cmd.kind)
                KIND_POLL: begin
                    sleep_out          = sleep_pending_reg;
                    sleep_pending_next = 1'b0;
                    if (cmd.buttons != BTN_NONE) begin
                        idle_count_next = '0;
                    end
                    inc_pending_next = 1'b0;
                    if (page_reg == PAGE_SETTINGS) begin
                        write_out = 1'b1;
                        if (inc_pending_reg) begin
                            held_next = bumped;
                        end
                        unique case (cmd.buttons)
                            BTN_BOTH:  page_next = PAGE_CLOCK;
                            BTN_RIGHT: field_next = (field_reg == FIELD_WEEKDAY ||
                                                     field_reg > FIELD_WEEKDAY) ?
                                                    FIELD_HOUR :
                                                    field_t'(field_reg + 3'd1);
                            BTN_LEFT:  inc_pending_next = 1'b1;
                            BTN_NONE:  page_next = page_reg;
                        endcase
                    end else begin
                        field_next = FIELD_HOUR;
                        if (cmd.buttons == BTN_BOTH) begin
                            page_next = (page_reg == PAGE_CLOCK) ? PAGE_BINARY : PAGE_SETTINGS;
                        end
                    end
                end
                KIND_TICK: begin
                    if (idle_inc >= sleep_ticks_reg) begin
                        sleep_pending_next = 1'b1;
                        idle_count_next    = '0;
                    end else begin
                        idle_count_next = idle_inc;
                    end
                end
                KIND_LOAD: begin
                    held_next = cmd.load_time;
                end
                KIND_NONE: begin
                    held_next = held_reg;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (pop) begin
            out_valid_next            = 1'b1;
            result_next.page          = page_next;
            result_next.field         = field_next;
            result_next.held          = held_next;
            result_next.sleep_request = sleep_out;
            result_next.clock_write   = write_out;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sleep_ticks_reg   <= SLEEP_TICKS_RESET;
            page_reg          <= PAGE_CLOCK;
            field_reg         <= FIELD_HOUR;
            inc_pending_reg   <= 1'b0;
            idle_count_reg    <= '0;
            sleep_pending_reg <= 1'b0;
            held_reg.hours    <= HOUR_RESET;
            held_reg.minutes  <= MINUTE_RESET;
            held_reg.seconds  <= SECOND_RESET;
            held_reg.date     <= DATE_RESET;
            held_reg.month    <= MONTH_RESET;
            held_reg.year     <= YEAR_RESET;
            held_reg.weekday  <= WEEKDAY_RESET;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                sleep_ticks_reg <= cfg_data;
            end
            page_reg          <= page_next;
            field_reg         <= field_next;
            inc_pending_reg   <= inc_pending_next;
            idle_count_reg    <= idle_count_next;
            sleep_pending_reg <= sleep_pending_next;
            held_reg          <= held_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

// ===== src/watch_menu_time_setter.sv =====
// Two-button watch menu controller. Each transfer on the s_ side carries one
// item: a poll with debounced button presses, a timer tick, or a time load,
// selected by s_tuser. Every item yields exactly one result transfer on the
// m_ side holding the page, the selected field, the held time and date, and
// the sleep_request and clock_write flags for that item. A front end unpacks
// and classifies items into a small queue; a back end applies each item to
// the menu state and places the result in an output register. The block
// sustains one item per clock cycle: the back end retires one queue entry
// every cycle that the output register is empty or being drained, and the
// input side keeps accepting while the queue has room, so a stalled output
// fills the queue of QUEUE_DEPTH entries before s_tready drops. An item is
// registered in a queue entry and then in the output register. The
// sleep_ticks register is written through the cfg_ channel, which is always
// ready; write it only while no item is in flight.
module watch_menu_time_setter import wmts_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // kind
    // right_press, left_press, hours, minutes, seconds, day_of_month,
    // month, year, weekday, zero fill
    input  logic [47:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // page, selected_field, out_hours, out_minutes, out_seconds, out_date,
    // out_month, out_year, out_weekday, sleep_request, clock_write, zero fill
    output logic [47:0] m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // sleep_ticks
);

    logic      push;
    logic      queue_full;
    cmd_t      front_cmd;
    cmd_t      queue_cmd;
    queue_hs_t queue_hs;
    logic      back_pop;
    result_t   result;

    // The register is a plain flop, so configuration never waits.
    assign cfg_ready = 1'b1;

    wmts_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (front_cmd)
    );

    wmts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (queue_full),
        .hs_out   (queue_hs),
        .pop      (back_pop),
        .pop_cmd  (queue_cmd)
    );

    wmts_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .queue_valid (queue_hs.valid),
        .cmd         (queue_cmd),
        .pop         (back_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .result      (result)
    );

    // Pack the result with the first field in the lowest bits.
    assign m_tdata = {1'b0,
                      result.clock_write,
                      result.sleep_request,
                      result.held.weekday,
                      result.held.year,
                      result.held.month,
                      result.held.date,
                      result.held.seconds,
                      result.held.minutes,
                      result.held.hours,
                      result.field,
                      result.page};

    // The back end must never retire an entry from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        queue_hs.pop |-> queue_hs.valid)
        else $error("back end popped an empty queue");

    // No result may be offered in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The selected field only ever walks through the seven time fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:2] != 3'd7))
        else $error("selected field out of range");

    // While the output register is stalled, a queued entry must stay queued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !queue_hs.pop)
        else $error("entry popped while the output is stalled");

endmodule

// ===== tb/sv/tb_watch_menu_time_setter.sv =====
`timescale 1ns / 1ps

module tb_watch_menu_time_setter;
    import wmts_pkg::*;

    // One input item as the testbench sees it, before packing onto the stream.
    typedef struct {
        kind_t       kind;
        logic        right;
        logic        left;
        clock_time_t t;
    } menu_item_t;

    // One result, unpacked from m_tdata field by field.
    typedef struct packed {
        logic [1:0]  page;
        logic [2:0]  sel;
        clock_time_t held;
        logic        sleep_request;
        logic        clock_write;
    } menu_view_t;

    // A row of the directed script. When typed is set, want holds the result
    // written out by hand; otherwise the result comes from the menu model.
    typedef struct {
        menu_item_t item;
        bit         typed;
        menu_view_t want;
    } script_row_t;

    localparam clock_time_t HELD_AT_RESET = '{hours: HOUR_RESET, minutes: MINUTE_RESET,
        seconds: SECOND_RESET, date: DATE_RESET, month: MONTH_RESET, year: YEAR_RESET,
        weekday: WEEKDAY_RESET};
    localparam clock_time_t TOP_OF_RANGE = '{hours: HOUR_MAX, minutes: MINUTE_MAX,
        seconds: SECOND_MAX, date: DATE_LONG, month: MONTH_MAX, year: YEAR_MAX,
        weekday: WEEKDAY_MAX};
    localparam clock_time_t ALL_BITS_SET = '1;

    localparam int unsigned PHASES    = 6;
    localparam int unsigned PER_PHASE = 190;
    localparam int unsigned SHOW_MAX  = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Menu model state, kept in step with every accepted transfer.
    page_t       menu_page   = PAGE_CLOCK;
    field_t      menu_field  = FIELD_HOUR;
    logic        bump_armed  = 1'b0;
    logic [15:0] idle_ticks  = '0;
    logic        sleep_owed  = 1'b0;
    clock_time_t held_time   = HELD_AT_RESET;
    logic [15:0] sleep_limit = SLEEP_TICKS_RESET;

    menu_view_t  expected_views[$];
    script_row_t script[$];
    int unsigned mismatches = 0;
    // Set for the last phase: neither side pauses at random from then on.
    bit          calm = 1'b0;

    watch_menu_time_setter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Date limit for the given month; any month value outside 1..12 counts
    // as the short February-like month.
    function automatic logic [4:0] days_in(logic [3:0] m);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return DATE_LONG;
            4'd4, 4'd6, 4'd9, 4'd11: return DATE_SHORT;
            default: return DATE_OTHER;
        endcase
    endfunction

    // Adds one to the field under edit. Every comparison is ">= limit" so that
    // values loaded outside their range also wrap on their next increment.
    function automatic void bump_selected();
        case (menu_field)
            FIELD_HOUR:
                held_time.hours = (held_time.hours >= HOUR_MAX) ? '0 : held_time.hours + 5'd1;
            FIELD_MINUTE:
                held_time.minutes = (held_time.minutes >= MINUTE_MAX) ?
                    '0 : held_time.minutes + 6'd1;
            FIELD_SECOND:
                held_time.seconds = (held_time.seconds >= SECOND_MAX) ?
                    '0 : held_time.seconds + 6'd1;
            FIELD_DATE:
                held_time.date = (held_time.date >= days_in(held_time.month)) ?
                    5'd1 : held_time.date + 5'd1;
            FIELD_MONTH:
                held_time.month = (held_time.month >= MONTH_MAX) ? 4'd1 : held_time.month + 4'd1;
            FIELD_YEAR:
                held_time.year = (held_time.year >= YEAR_MAX) ? YEAR_MIN : held_time.year + 11'd1;
            FIELD_WEEKDAY:
                held_time.weekday = (held_time.weekday >= WEEKDAY_MAX) ?
                    3'd1 : held_time.weekday + 3'd1;
            default: ;
        endcase
    endfunction

    // Applies one item to the menu model and returns the result it yields.
    function automatic menu_view_t step_menu(menu_item_t it);
        menu_view_t v;
        logic       sleep_now;
        logic       write_now;
        sleep_now = 1'b0;
        write_now = 1'b0;
        case (it.kind)
            KIND_POLL: begin
                // A sleep request raised by an earlier tick is reported once.
                if (sleep_owed) begin
                    sleep_now  = 1'b1;
                    sleep_owed = 1'b0;
                end
                if (it.right || it.left) begin
                    idle_ticks = '0;
                end
                if (menu_page == PAGE_SETTINGS) begin
                    // The increment armed by the previous poll lands first,
                    // then the buttons of this poll are decoded.
                    if (bump_armed) begin
                        bump_selected();
                    end
                    write_now  = 1'b1;
                    bump_armed = 1'b0;
                    if (it.right && it.left) begin
                        menu_page = PAGE_CLOCK;
                    end else if (it.right) begin
                        menu_field = (menu_field >= FIELD_WEEKDAY) ?
                            FIELD_HOUR : field_t'(menu_field + 3'd1);
                    end else if (it.left) begin
                        bump_armed = 1'b1;
                    end
                end else begin
                    menu_field = FIELD_HOUR;
                    bump_armed = 1'b0;
                    if (it.right && it.left) begin
                        menu_page = page_t'(menu_page + 2'd1);
                    end
                end
            end
            KIND_TICK: begin
                idle_ticks = idle_ticks + 16'd1;
                if (idle_ticks >= sleep_limit) begin
                    sleep_owed = 1'b1;
                    idle_ticks = '0;
                end
            end
            KIND_LOAD: begin
                held_time = it.t;
            end
            default: ;
        endcase
        v.page          = menu_page;
        v.sel           = menu_field;
        v.held          = held_time;
        v.sleep_request = sleep_now;
        v.clock_write   = write_now;
        return v;
    endfunction

    function automatic menu_item_t item(kind_t k, logic r, logic l, clock_time_t t);
        menu_item_t it;
        it.kind  = k;
        it.right = r;
        it.left  = l;
        it.t     = t;
        return it;
    endfunction

    function automatic menu_view_t shows(page_t pg, clock_time_t t);
        menu_view_t v;
        v.page          = pg;
        v.sel           = FIELD_HOUR;
        v.held          = t;
        v.sleep_request = 1'b0;
        v.clock_write   = 1'b0;
        return v;
    endfunction

    function automatic void add_row(menu_item_t it, bit typed, menu_view_t want);
        script_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endfunction

    function automatic string describe(menu_view_t v);
        return $sformatf({"page %0d field %0d time %0d:%0d:%0d date %0d.%0d.%0d",
                          " wd %0d sleep %0b write %0b"},
            v.page, v.sel, v.held.hours, v.held.minutes, v.held.seconds, v.held.date,
            v.held.month, v.held.year, v.held.weekday, v.sleep_request, v.clock_write);
    endfunction

    // Mostly legal times with the month-end dates favored, so that date
    // increments hit the 29, 30 and 31 limits; now and then raw bits.
    function automatic clock_time_t random_time();
        clock_time_t t;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) begin
            t = raw[39:0];
        end else begin
            t.hours   = 5'($urandom_range(0, 23));
            t.minutes = 6'($urandom_range(0, 59));
            t.seconds = 6'($urandom_range(0, 59));
            t.date    = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(28, 31)) :
                                                      5'($urandom_range(1, 31));
            t.month   = 4'($urandom_range(1, 12));
            t.year    = 11'($urandom_range(2020, 2030));
            t.weekday = 3'($urandom_range(1, 7));
        end
        return t;
    endfunction

    // Polls dominate so that the settings page is reached and edited often;
    // ticks feed the idle counter, loads refresh the held time, and the
    // unused kind turns up now and then.
    function automatic menu_item_t random_item();
        int unsigned pick;
        logic [1:0]  presses;
        kind_t       k;
        pick    = $urandom_range(0, 99);
        presses = 2'($urandom_range(0, 3));
        if (pick < 50) begin
            k = KIND_POLL;
        end else if (pick < 85) begin
            k = KIND_TICK;
        end else if (pick < 97) begin
            k = KIND_LOAD;
        end else begin
            k = KIND_NONE;
        end
        return item(k, presses[0], presses[1], random_time());
    endfunction

    // Directed script: reset values, the unused kind, loads at the top and
    // bottom of every range and with every bit set, then a walk through the
    // settings page that increments each field once, hours twice. The all-ones
    // load leaves month 15, so the date wraps at 29; the weekday wraps from 7,
    // and every other field wraps from an out-of-range value.
    function automatic void build_script();
        add_row(item(KIND_POLL, 1'b0, 1'b0, ALL_BITS_SET), 1'b1, shows(PAGE_CLOCK, HELD_AT_RESET));
        add_row(item(KIND_TICK, 1'b0, 1'b0, ALL_BITS_SET), 1'b1, shows(PAGE_CLOCK, HELD_AT_RESET));
        add_row(item(KIND_NONE, 1'b1, 1'b1, ALL_BITS_SET), 1'b1, shows(PAGE_CLOCK, HELD_AT_RESET));
        add_row(item(KIND_LOAD, 1'b1, 1'b1, TOP_OF_RANGE), 1'b1, shows(PAGE_CLOCK, TOP_OF_RANGE));
        add_row(item(KIND_LOAD, 1'b0, 1'b0, HELD_AT_RESET), 1'b1, shows(PAGE_CLOCK, HELD_AT_RESET));
        add_row(item(KIND_LOAD, 1'b0, 1'b0, ALL_BITS_SET), 1'b1, shows(PAGE_CLOCK, ALL_BITS_SET));
        // Clock page, then binary clock page, then settings.
        add_row(item(KIND_POLL, 1'b1, 1'b1, '0), 1'b0, '0);
        add_row(item(KIND_POLL, 1'b1, 1'b1, '0), 1'b0, '0);
        // Arm, then let a right press land the increment and move on, for all
        // seven fields; the last right press wraps the selection to hours.
        for (int f = 0; f < 7; f++) begin
            add_row(item(KIND_POLL, 1'b0, 1'b1, '0), 1'b0, '0);
            add_row(item(KIND_POLL, 1'b1, 1'b0, '0), 1'b0, '0);
        end
        // Arm once more and leave the settings page with both buttons.
        add_row(item(KIND_POLL, 1'b0, 1'b1, '0), 1'b0, '0);
        add_row(item(KIND_POLL, 1'b1, 1'b1, '0), 1'b0, '0);
        add_row(item(KIND_POLL, 1'b0, 1'b0, '0), 1'b0, '0);
    endfunction

    // Waits until every expected result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (expected_views.size() != 0);
    endtask

    // Sender idling: a random burst of empty cycles before some items.
    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // Offers one item and holds it until the transfer completes, then records
    // the result it must produce.
    task automatic send_item(menu_item_t it, bit typed, menu_view_t want);
        menu_view_t modeled;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {6'd0, it.t.weekday, it.t.year, it.t.month, it.t.date,
                     it.t.seconds, it.t.minutes, it.t.hours, it.left, it.right};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        modeled = step_menu(it);
        expected_views.push_back(typed ? want : modeled);
    endtask

    // Writes the sleep limit while nothing is in flight.
    task automatic write_sleep_limit(logic [15:0] ticks);
        drain();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid   <= 1'b0;
        sleep_limit  = ticks;
    endtask

    initial begin : stimulus
        logic [15:0] limits [PHASES];
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        // One request per tick, a limit of zero (every tick requests sleep),
        // the largest limit, a short random one, a fully random one, and a
        // short one for the final phase without random pauses.
        limits[0] = 16'd1;
        limits[1] = 16'd0;
        limits[2] = 16'hFFFF;
        limits[3] = 16'($urandom_range(2, 12));
        limits[4] = 16'($urandom);
        limits[5] = 16'd3;
        build_script();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // The directed part runs with the sleep limit left at its reset value.
        foreach (script[i]) begin
            maybe_pause();
            send_item(script[i].item, script[i].typed, script[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_sleep_limit(limits[p]);
            if (p == PHASES - 1) begin
                calm = 1'b1;
            end
            for (int k = 0; k < PER_PHASE; k++) begin
                // Halfway through each phase the sender holds off until the
                // block has nothing left to deliver.
                if (k == PER_PHASE / 2) begin
                    drain();
                end
                maybe_pause();
                send_item(random_item(), 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        mismatches += expected_views.size();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver stalls in random bursts, none once the final phase begins.
    initial begin : result_stalls
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!calm && aresetn && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Every result transfer is matched against the oldest expectation.
    always @(posedge aclk) begin : check_results
        menu_view_t got;
        menu_view_t want;
        string      bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.page          = m_tdata[1:0];
            got.sel           = m_tdata[4:2];
            got.held.hours    = m_tdata[9:5];
            got.held.minutes  = m_tdata[15:10];
            got.held.seconds  = m_tdata[21:16];
            got.held.date     = m_tdata[26:22];
            got.held.month    = m_tdata[30:27];
            got.held.year     = m_tdata[41:31];
            got.held.weekday  = m_tdata[44:42];
            got.sleep_request = m_tdata[45];
            got.clock_write   = m_tdata[46];
            if (expected_views.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX) begin
                    $display("%0t: result with nothing expected: %s", $realtime, describe(got));
                end
            end else begin
                want = expected_views.pop_front();
                bad  = "";
                if (got.page !== want.page) bad = {bad, " page"};
                if (got.sel !== want.sel) bad = {bad, " selected_field"};
                if (got.held.hours !== want.held.hours) bad = {bad, " hours"};
                if (got.held.minutes !== want.held.minutes) bad = {bad, " minutes"};
                if (got.held.seconds !== want.held.seconds) bad = {bad, " seconds"};
                if (got.held.date !== want.held.date) bad = {bad, " date"};
                if (got.held.month !== want.held.month) bad = {bad, " month"};
                if (got.held.year !== want.held.year) bad = {bad, " year"};
                if (got.held.weekday !== want.held.weekday) bad = {bad, " weekday"};
                if (got.sleep_request !== want.sleep_request) bad = {bad, " sleep_request"};
                if (got.clock_write !== want.clock_write) bad = {bad, " clock_write"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX) begin
                        $display("%0t: mismatch in%s\n  expected %s\n  actual   %s",
                            $realtime, bad, describe(want), describe(got));
                    end
                end
            end
        end
    end

    // A correct run needs well under 100000 ns even with the longest stalls
    // on both sides; anything far beyond that means the block has hung.
    initial begin : watchdog
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule
